>>> design/rational_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// concurrent check helpers used by the rau_controller module
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDTH  = 16;
   localparam int PW     = (2 * WIDTH + 1 > 64) ? 64 : 2 * WIDTH + 1;
   localparam int CNT_W  = $clog2(PW);
   localparam int NUM_W  = 33;
   localparam int DEN_W  = 31;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_DEN_ZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MUL_P0 = 2'd0,
      MUL_P1 = 2'd1,
      MUL_P2 = 2'd2
   } mul_sel_type;

   typedef struct packed {
      op_type                   opcode;
      logic signed [WIDTH-1:0]  num_a;
      logic signed [WIDTH-1:0]  den_a;
      logic signed [WIDTH-1:0]  num_b;
      logic signed [WIDTH-1:0]  den_b;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0]  reduced_num;
      logic [DEN_W-1:0]         reduced_den;
      status_type               status;
   } rsp_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        num_first;
      logic        num_acc;
      logic        prep;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic gcd_done;
   } dp_status_type;

endpackage

>>> design/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// cross-product multiplier, binary gcd unit and dual-lane restoring divider
// ----------------------------------------------------------------------------
module rau_datapath (
   input  logic                   clock,
   input  rau_pkg::cmd_type       cmd,
   input  rau_pkg::req_type       req_data,
   output rau_pkg::dp_status_type status,
   output rau_pkg::rsp_type       rsp_data
);

   localparam int W      = rau_pkg::WIDTH;
   localparam int PW     = rau_pkg::PW;
   localparam int PROD_W = 2 * W;

   function automatic logic [2*PW-1:0] div_lane(input logic [PW-1:0] rem,
                                                 input logic [PW-1:0] quo,
                                                 input logic [PW-1:0] dvs);
      logic [PW:0] trial;
      logic [PW:0] diff;
      trial = {rem, quo[PW-1]};
      diff  = trial - {1'b0, dvs};
      if (diff[PW]) begin
         return {trial[PW-1:0], quo[PW-2:0], 1'b0};
      end
      return {diff[PW-1:0], quo[PW-2:0], 1'b1};
   endfunction

   rau_pkg::req_type       op_ff, op_in;
   rau_pkg::status_type    err_ff, err_in;
   logic signed [2*W-1:0]  prod_ff, prod_in;
   logic signed [PW-1:0]   rn_ff, rn_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;
   logic [PW-1:0]          a_ff, a_in, b_ff, b_in;
   logic [PW-1:0]          u_ff, u_in, v_ff, v_in;
   logic [PW-1:0]          d_ff, d_in;
   logic [PW-1:0]          qn_ff, qn_in, qd_ff, qd_in;
   logic [PW-1:0]          rmn_ff, rmn_in, rmd_ff, rmd_in;
   rau_pkg::rsp_type       rsp_ff, rsp_in;

   logic signed [W-1:0]    mul_x, mul_y;
   logic signed [PW-1:0]   prod_ext;
   logic [PW-1:0]          mag_n, mag_d;
   logic [PW:0]            d_uv, d_vu;
   logic [2*PW-1:0]        lane_n, lane_d;
   logic [rau_pkg::NUM_W-1:0] num_mag;

   assign prod_ext = PW'(prod_ff);
   assign mag_n    = rn_ff[PW-1] ? ('0 - unsigned'(rn_ff)) : unsigned'(rn_ff);
   assign mag_d    = prod_ext[PW-1] ? ('0 - unsigned'(prod_ext)) : unsigned'(prod_ext);
   assign d_uv     = {1'b0, u_ff} - {1'b0, v_ff};
   assign d_vu     = {1'b0, v_ff} - {1'b0, u_ff};
   assign lane_n   = div_lane(rmn_ff, qn_ff, d_ff);
   assign lane_d   = div_lane(rmd_ff, qd_ff, d_ff);
   assign num_mag  = rau_pkg::NUM_W'(qn_ff);

   // multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         rau_pkg::MUL_P0: begin
            mul_x = op_ff.num_a;
            mul_y = (op_ff.opcode == rau_pkg::OP_MUL) ? op_ff.num_b : op_ff.den_b;
         end
         rau_pkg::MUL_P1: begin
            mul_x = op_ff.num_b;
            mul_y = op_ff.den_a;
         end
         rau_pkg::MUL_P2: begin
            mul_x = op_ff.den_a;
            mul_y = (op_ff.opcode == rau_pkg::OP_DIV) ? op_ff.num_b : op_ff.den_b;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   always_comb begin
      op_in   = op_ff;
      err_in  = err_ff;
      prod_in = prod_ff;
      rn_in   = rn_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      d_in    = d_ff;
      qn_in   = qn_ff;
      qd_in   = qd_ff;
      rmn_in  = rmn_ff;
      rmd_in  = rmd_ff;
      rsp_in  = rsp_ff;

      if (cmd.load) begin
         op_in = req_data;
         priority if (req_data.den_a == '0 || req_data.den_b == '0) begin
            err_in = rau_pkg::ST_DEN_ZERO;
         end else if (req_data.opcode == rau_pkg::OP_DIV && req_data.num_b == '0) begin
            err_in = rau_pkg::ST_DIV_ZERO;
         end else begin
            err_in = rau_pkg::ST_OK;
         end
      end

      if (cmd.mul_en) begin
         prod_in = PROD_W'(mul_x) * PROD_W'(mul_y);
      end

      if (cmd.num_first) begin
         rn_in = prod_ext;
      end else if (cmd.num_acc) begin
         if (op_ff.opcode == rau_pkg::OP_ADD) begin
            rn_in = rn_ff + prod_ext;
         end else if (op_ff.opcode == rau_pkg::OP_SUB) begin
            rn_in = rn_ff - prod_ext;
         end
      end

      // sign and magnitudes of the raw fraction
      if (cmd.prep) begin
         neg_in  = rn_ff[PW-1] ^ prod_ext[PW-1];
         zero_in = (rn_ff == '0) || (prod_ext == '0);
         a_in    = mag_n;
         b_in    = mag_d;
         u_in    = mag_n;
         v_in    = mag_d;
      end

      // binary gcd, common powers of two are stripped from the operands too
      if (cmd.gcd_step) begin
         priority if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (!d_uv[PW]) begin
            u_in = {1'b0, d_uv[PW-1:1]};
         end else begin
            v_in = {1'b0, d_vu[PW-1:1]};
         end
      end

      if (cmd.div_init) begin
         d_in   = u_ff | v_ff;
         qn_in  = a_ff;
         qd_in  = b_ff;
         rmn_in = '0;
         rmd_in = '0;
      end else if (cmd.div_step) begin
         rmn_in = lane_n[2*PW-1:PW];
         qn_in  = lane_n[PW-1:0];
         rmd_in = lane_d[2*PW-1:PW];
         qd_in  = lane_d[PW-1:0];
      end

      if (cmd.out_load) begin
         priority if (err_ff != rau_pkg::ST_OK) begin
            rsp_in.reduced_num = '0;
            rsp_in.reduced_den = '0;
            rsp_in.status      = err_ff;
         end else if (zero_ff) begin
            rsp_in.reduced_num = '0;
            rsp_in.reduced_den = rau_pkg::DEN_W'(1);
            rsp_in.status      = rau_pkg::ST_OK;
         end else begin
            rsp_in.reduced_num = neg_ff ? ('0 - num_mag) : num_mag;
            rsp_in.reduced_den = rau_pkg::DEN_W'(qd_ff);
            rsp_in.status      = rau_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      err_ff  <= err_in;
      prod_ff <= prod_in;
      rn_ff   <= rn_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      d_ff    <= d_in;
      qn_ff   <= qn_in;
      qd_ff   <= qd_in;
      rmn_ff  <= rmn_in;
      rmd_ff  <= rmd_in;
      rsp_ff  <= rsp_in;
   end

   assign status.err      = (err_ff != rau_pkg::ST_OK);
   assign status.gcd_done = (u_ff == '0) || (v_ff == '0);
   assign rsp_data        = rsp_ff;

endmodule

>>> design/rau_controller.sv
// ----------------------------------------------------------------------------
// rau_controller
// sequencer for multiply, gcd and divide phases plus the result handshake
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_assert.svh"

module rau_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rau_pkg::dp_status_type status,
   output rau_pkg::cmd_type       cmd
);

   localparam int CW = rau_pkg::CNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_PREP,
      S_GCD,
      S_DIV,
      S_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            if (status.err) begin
               state_in = S_FINISH;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = rau_pkg::MUL_P0;
               state_in    = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = rau_pkg::MUL_P1;
            cmd.num_first = 1'b1;
            state_in      = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rau_pkg::MUL_P2;
            cmd.num_acc = 1'b1;
            state_in    = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CW'(rau_pkg::PW - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `RAU_ASSERT_IMPL(a_out_slot_free, clock, reset, cmd.out_load, out_free, "rsp overwritten")
   `RAU_ASSERT_NEXT(a_accept_busy, clock, reset, cmd.load, !req_ready, "beat taken while busy")
   `RAU_ASSERT_IMPL(a_gcd_live, clock, reset, cmd.gcd_step, !status.gcd_done, "gcd overrun")
   `RAU_ASSERT_NEXT(a_load_valid, clock, reset, cmd.out_load, rsp_valid, "rsp_valid missing")

endmodule

>>> design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply or divide two fractions and reduce by their gcd
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  rau_pkg::req_type
//  rsp       out        rsp_valid / rsp_ready  rau_pkg::rsp_type
//
//  one beat at a time: after the accepting edge the sequencer forms the cross
//  products, sets up the gcd, runs binary gcd steps until one operand is zero,
//  starts the divider, runs its steps and then loads the output register;
//  error beats go from the first multiply state straight to the load
//  reset is synchronous and active high, clears the sequencer and rsp_valid
//  a new beat is taken while a finished result waits in the output register;
//  the next result is held until that register is free
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rau_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rau_pkg::rsp_type  rsp_data
);

   rau_pkg::cmd_type       cmd;
   rau_pkg::dp_status_type status;

   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rau_datapath u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rational arithmetic unit: a directed table of
// fractions covering zero denominators, zero divisors, zero numerators and
// the operand extremes, then random fractions under random idling and back
// pressure; every result beat is checked against its table entry or a gcd
// reduction predictor
module tb;
   import rau_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_BEATS   = 800;
   localparam int QUIET_BEATS    = 100;
   localparam int LONG_HOLD      = 600;
   localparam int HOLD_AFTER     = 120;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type     expected_fractions[$];
   dir_row_type dir_table[$];
   int          errors        = 0;
   int          beats_sent    = 0;
   int          beats_checked = 0;
   int          count_ok      = 0;
   int          count_div0    = 0;
   int          count_den0    = 0;
   int          idle_cycles   = 0;
   bit          no_idle       = 1'b0;

   rational_arithmetic_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [63:0] widen(logic [WIDTH-1:0] v);
      return {{(64-WIDTH){v[WIDTH-1]}}, v};
   endfunction

   function automatic logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic rsp_type reduce_rational(req_type r);
      logic [63:0] na, da, nb, db, rn, rd, mn, md, x, y, t, sn;
      logic        neg;
      rsp_type     o;
      na = widen(r.num_a);
      da = widen(r.den_a);
      nb = widen(r.num_b);
      db = widen(r.den_b);
      o = '0;
      if (da == 64'd0 || db == 64'd0) begin
         o.status = ST_DEN_ZERO;
         return o;
      end
      if (r.opcode == OP_DIV && nb == 64'd0) begin
         o.status = ST_DIV_ZERO;
         return o;
      end
      case (r.opcode)
         OP_ADD: begin
            rn = na * db + nb * da;
            rd = da * db;
         end
         OP_SUB: begin
            rn = na * db - nb * da;
            rd = da * db;
         end
         OP_MUL: begin
            rn = na * nb;
            rd = da * db;
         end
         default: begin
            rn = na * db;
            rd = da * nb;
         end
      endcase
      o.status = ST_OK;
      if (rn == 64'd0 || rd == 64'd0) begin
         o.reduced_den = DEN_W'(1);
         return o;
      end
      neg = rn[63] ^ rd[63];
      mn = magnitude(rn);
      md = magnitude(rd);
      x = mn;
      y = md;
      while (y != 64'd0) begin
         t = x % y;
         x = y;
         y = t;
      end
      if (x != 64'd0) begin
         mn = mn / x;
         md = md / x;
      end
      sn = neg ? (64'd0 - mn) : mn;
      o.reduced_num = sn[NUM_W-1:0];
      o.reduced_den = md[DEN_W-1:0];
      return o;
   endfunction

   function automatic dir_row_type make_row(op_type op, int na, int da, int nb, int db,
                                            bit known, longint en, longint ed,
                                            status_type st);
      dir_row_type row;
      row.req.opcode      = op;
      row.req.num_a       = na[WIDTH-1:0];
      row.req.den_a       = da[WIDTH-1:0];
      row.req.num_b       = nb[WIDTH-1:0];
      row.req.den_b       = db[WIDTH-1:0];
      row.known           = known;
      row.rsp.reduced_num = en[NUM_W-1:0];
      row.rsp.reduced_den = ed[DEN_W-1:0];
      row.rsp.status      = st;
      return row;
   endfunction

   function automatic logic [WIDTH-1:0] rand_operand();
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 4))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3: v = 1;
            default: v = -1;
         endcase
      end else if (pick <= 3) begin
         v = $urandom_range(0, 32) - 16;
      end else begin
         v = $urandom;
      end
      return v[WIDTH-1:0];
   endfunction

   task automatic send_beat(input req_type r, input rsp_type e, input bit may_idle);
      int gap;
      if (may_idle && !no_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_fractions.push_back(e);
      beats_sent++;
      case (e.status)
         ST_OK:       count_ok++;
         ST_DIV_ZERO: count_div0++;
         default:     count_den0++;
      endcase
   endtask

   // stimulus side
   initial begin
      req_type r;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      dir_table.push_back(make_row(OP_ADD,      1,      1,      1,      1, 1,  2, 1, ST_OK));
      dir_table.push_back(make_row(OP_ADD,      1,      0,      1,      1, 1,  0, 0,
                                   ST_DEN_ZERO));
      dir_table.push_back(make_row(OP_SUB,      1,      1,      1,      0, 1,  0, 0,
                                   ST_DEN_ZERO));
      dir_table.push_back(make_row(OP_DIV,      5,      0,      0,      3, 1,  0, 0,
                                   ST_DEN_ZERO));
      dir_table.push_back(make_row(OP_DIV,      5,      3,      0,      7, 1,  0, 0,
                                   ST_DIV_ZERO));
      dir_table.push_back(make_row(OP_MUL,      0,      5,      3,      7, 1,  0, 1, ST_OK));
      dir_table.push_back(make_row(OP_SUB,      3,      4,      3,      4, 1,  0, 1, ST_OK));
      dir_table.push_back(make_row(OP_ADD,      0,     -1,      0,      1, 1,  0, 1, ST_OK));
      dir_table.push_back(make_row(OP_DIV,      0,      3,      5,      7, 1,  0, 1, ST_OK));
      dir_table.push_back(make_row(OP_SUB,     -1,     -1,      1,      1, 1,  0, 1, ST_OK));
      dir_table.push_back(make_row(OP_MUL, -32768,      1, -32768,      1, 1,
                                   1073741824, 1, ST_OK));
      dir_table.push_back(make_row(OP_MUL,      1, -32768,      1, -32768, 1,
                                   1, 1073741824, ST_OK));
      dir_table.push_back(make_row(OP_MUL,  32767,      1,  32767,      1, 1,
                                   1073676289, 1, ST_OK));
      dir_table.push_back(make_row(OP_ADD, -32768,      1, -32768,      1, 1,
                                   -65536, 1, ST_OK));
      dir_table.push_back(make_row(OP_DIV, -32768, -32768, -32768, -32768, 1,
                                   1, 1, ST_OK));
      dir_table.push_back(make_row(OP_ADD,      1,      2,      1,      3, 1,  5, 6, ST_OK));
      dir_table.push_back(make_row(OP_MUL,      2,     -4,      3,      9, 1, -1, 6, ST_OK));
      dir_table.push_back(make_row(OP_DIV,      1,      2,     -1,      4, 1, -2, 1, ST_OK));
      dir_table.push_back(make_row(OP_SUB,  32767, -32768, -32768,  32767, 0,  0, 0, ST_OK));
      dir_table.push_back(make_row(OP_DIV, -32768,  32767,  32767, -32768, 0,  0, 0, ST_OK));
      dir_table.push_back(make_row(OP_ADD,  32767,  32767,  32767, -32768, 0,  0, 0, ST_OK));
      dir_table.push_back(make_row(OP_SUB,  21845, -21846, -21846,  21845, 0,  0, 0, ST_OK));
      dir_table.push_back(make_row(OP_MUL, -21846,  21845,  21845, -21846, 0,  0, 0, ST_OK));
      dir_table.push_back(make_row(OP_DIV,     -1,     -1,     -1,     -1, 0,  0, 0, ST_OK));

      foreach (dir_table[i])
         send_beat(dir_table[i].req,
                   dir_table[i].known ? dir_table[i].rsp : reduce_rational(dir_table[i].req),
                   1'b1);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         r.opcode = op_type'($urandom_range(0, 3));
         r.num_a  = rand_operand();
         r.den_a  = rand_operand();
         r.num_b  = rand_operand();
         r.den_b  = rand_operand();
         if (i == 400) begin
            // let the unit drain completely before going on
            req_valid <= 1'b0;
            while (expected_fractions.size() != 0) @(posedge clock);
         end
         if (i == RANDOM_BEATS - QUIET_BEATS)
            no_idle = 1'b1;
         send_beat(r, reduce_rational(r), !(i >= 250 && i < 350));
      end

      req_valid <= 1'b0;
      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats: %0d ok, %0d zero divisor, %0d zero denominator",
               beats_sent, count_ok, count_div0, count_den0);
      $display("checked %0d result beats, %0d mismatches", beats_checked, errors);
      if (errors == 0) begin
         $display("PASS rational_arithmetic_unit");
      end else begin
         $display("FAIL rational_arithmetic_unit");
      end
      $finish;
   end

   // result side
   initial begin
      rsp_type exp_rsp;
      int      stall_left;
      int      phase_left;
      bit      may_stall;
      bit      long_done;
      stall_left = 0;
      phase_left = 0;
      may_stall  = 1'b0;
      long_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (expected_fractions.size() == 0) begin
               $display("%0t: unexpected result beat, got %0d/%0d status %0d", $time,
                        rsp_data.reduced_num, rsp_data.reduced_den, rsp_data.status);
               errors++;
            end else begin
               exp_rsp = expected_fractions.pop_front();
               if (rsp_data.reduced_num !== exp_rsp.reduced_num) begin
                  $display("%0t: reduced_num mismatch, expected %0d, got %0d", $time,
                           exp_rsp.reduced_num, rsp_data.reduced_num);
                  errors++;
               end
               if (rsp_data.reduced_den !== exp_rsp.reduced_den) begin
                  $display("%0t: reduced_den mismatch, expected %0d, got %0d", $time,
                           exp_rsp.reduced_den, rsp_data.reduced_den);
                  errors++;
               end
               if (rsp_data.status !== exp_rsp.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d", $time,
                           exp_rsp.status, rsp_data.status);
                  errors++;
               end
            end
         end
         // one long back pressure stretch so the input side fills up
         if (!long_done && beats_checked >= HOLD_AFTER) begin
            long_done  = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(50, 400);
            may_stall  = ($urandom_range(0, 2) != 0);
         end else begin
            phase_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (may_stall && !no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL rational_arithmetic_unit");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> filelist.f
+incdir+design
design/rau_pkg.sv
design/rau_datapath.sv
design/rau_controller.sv
design/rational_arithmetic_unit.sv
tb/tb.sv
